// ===== sv/ffisa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffisa_pkg
// Shared types and constants of the first-fit interval slot allocator.
// ----------------------------------------------------------------------------
package ffisa_pkg;

	localparam int DEF_MAX_SLOTS = 64;
	localparam int DEF_POS_BITS  = 16;
	localparam int DEF_SYM_BITS  = 16;

	localparam int CNT_W      = 16;
	localparam int SLOT_OUT_W = 6;
	localparam int ALIAS_W    = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// flags of one beat moving down the slot chain
	typedef struct packed {
		logic valid;
		logic pinned;
		logic group_end;
		logic stream_end;
		logic placed;
		logic reused;
		logic alias_valid;
	} flags_t;

endpackage
`default_nettype wire

// ===== sv/ffisa_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffisa_cell
// One slot of the chain: holds the slot's end and first owner, tries to place
// the passing interval and forwards the beat to its neighbor.
// ----------------------------------------------------------------------------
module ffisa_cell #(
	parameter int POS_BITS = ffisa_pkg::DEF_POS_BITS,
	parameter int SYM_BITS = ffisa_pkg::DEF_SYM_BITS,
	parameter int SLOT_W   = 6,
	parameter int IDX      = 0
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      advance,
	input  wire                      alias_enable,
	input  wire ffisa_pkg::flags_t   flags_i,
	input  wire     [SYM_BITS-1:0]   sym_i,
	input  wire     [POS_BITS-1:0]   start_i,
	input  wire     [POS_BITS-1:0]   end_i,
	input  wire     [SLOT_W-1:0]     slot_i,
	input  wire     [SYM_BITS-1:0]   asym_i,
	output ffisa_pkg::flags_t        flags_o,
	output logic    [SYM_BITS-1:0]   sym_o,
	output logic    [POS_BITS-1:0]   start_o,
	output logic    [POS_BITS-1:0]   end_o,
	output logic    [SLOT_W-1:0]     slot_o,
	output logic    [SYM_BITS-1:0]   asym_o
);

	localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

	logic                open_q;
	logic [POS_BITS-1:0] end_q;
	logic [SYM_BITS-1:0] owner_q;

	ffisa_pkg::flags_t   flags_q;
	logic [SYM_BITS-1:0] sym_q;
	logic [POS_BITS-1:0] start_q;
	logic [POS_BITS-1:0] end_pos_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SYM_BITS-1:0] asym_q;

	logic hit, fit, take, do_alias;
	ffisa_pkg::flags_t flags_n;

	always_comb begin
		hit      = flags_i.valid && !flags_i.pinned && !flags_i.placed;
		fit      = hit && open_q && (end_q < start_i);
		take     = hit && !open_q;
		do_alias = fit && alias_enable && (owner_q != sym_i);
		flags_n  = flags_i;
		flags_n.placed      = flags_i.placed | fit | take;
		flags_n.reused      = flags_i.reused | fit;
		flags_n.alias_valid = flags_i.alias_valid | do_alias;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			flags_q <= '0;
		end else if (advance) begin
			flags_q <= flags_n;
			if (flags_i.valid && flags_i.group_end) begin
				open_q <= 1'b0;
			end else if (take) begin
				open_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (fit || take) begin
				end_q <= end_i;
			end
			if (take) begin
				owner_q <= sym_i;
			end
			sym_q     <= sym_i;
			start_q   <= start_i;
			end_pos_q <= end_i;
			slot_q    <= (fit || take) ? MY_IDX : slot_i;
			asym_q    <= do_alias ? owner_q : asym_i;
		end
	end

	assign flags_o = flags_q;
	assign sym_o   = sym_q;
	assign start_o = start_q;
	assign end_o   = end_pos_q;
	assign slot_o  = slot_q;
	assign asym_o  = asym_q;

endmodule
`default_nettype wire

// ===== sv/ffisa_tally.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffisa_tally
// End of the chain: group and stream counters and the output register.
// ----------------------------------------------------------------------------
module ffisa_tally #(
	parameter int MAX_SLOTS = ffisa_pkg::DEF_MAX_SLOTS,
	parameter int SYM_BITS  = ffisa_pkg::DEF_SYM_BITS,
	parameter int SLOT_W    = 6
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   advance,
	input  wire ffisa_pkg::flags_t                flags_i,
	input  wire     [SLOT_W-1:0]                  slot_i,
	input  wire     [SYM_BITS-1:0]                asym_i,
	output logic                                  valid_o,
	output logic    [ffisa_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic                                  assigned,
	output logic                                  reused,
	output logic                                  alias_valid,
	output logic    [ffisa_pkg::ALIAS_W-1:0]      alias_symbol,
	output logic                                  overflow,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_virtual,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_physical,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_pinned,
	output logic    [ffisa_pkg::CNT_W-1:0]        physical_total,
	output logic                                  last
);

	localparam int CW     = ffisa_pkg::CNT_W;
	localparam int OPEN_W = $clog2(MAX_SLOTS + 1);
	localparam int SX_W   = (SLOT_W > ffisa_pkg::SLOT_OUT_W) ? SLOT_W : ffisa_pkg::SLOT_OUT_W;
	localparam int AX_W   = (SYM_BITS > ffisa_pkg::ALIAS_W) ? SYM_BITS : ffisa_pkg::ALIAS_W;

	logic [CW-1:0]     intv_q, pin_q, psum_q;
	logic [OPEN_W-1:0] open_q;

	logic [CW-1:0]     intv_n, pin_n, phys_n, psum_n;
	logic [OPEN_W-1:0] open_n;
	logic [CW:0]       s_intv, s_pin, s_phys, s_psum;
	logic [SX_W-1:0]   slot_x;
	logic [AX_W-1:0]   asym_x;

	logic              valid_q;
	logic [ffisa_pkg::SLOT_OUT_W-1:0] slot_q;
	logic              assigned_q, reused_q, alias_q, ovf_q, last_q;
	logic [ffisa_pkg::ALIAS_W-1:0]    asym_q;
	logic [CW-1:0]     gvirt_q, gphys_q, gpin_q, tphys_q;

	always_comb begin
		s_intv = {1'b0, intv_q} + (CW+1)'(1);
		intv_n = s_intv[CW] ? ffisa_pkg::CNT_MAX : s_intv[CW-1:0];
		s_pin  = {1'b0, pin_q} + (CW+1)'(1);
		pin_n  = pin_q;
		if (flags_i.pinned) begin
			pin_n = s_pin[CW] ? ffisa_pkg::CNT_MAX : s_pin[CW-1:0];
		end
		open_n = open_q;
		if (flags_i.placed && !flags_i.reused) begin
			open_n = open_q + OPEN_W'(1);
		end
		s_phys = (CW+1)'(open_n) + {1'b0, pin_n};
		phys_n = s_phys[CW] ? ffisa_pkg::CNT_MAX : s_phys[CW-1:0];
		s_psum = {1'b0, psum_q} + {1'b0, phys_n};
		psum_n = psum_q;
		if (flags_i.group_end) begin
			psum_n = s_psum[CW] ? ffisa_pkg::CNT_MAX : s_psum[CW-1:0];
		end
		slot_x = SX_W'(slot_i);
		asym_x = AX_W'(asym_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intv_q  <= '0;
			pin_q   <= '0;
			open_q  <= '0;
			psum_q  <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= flags_i.valid;
			if (flags_i.valid) begin
				if (flags_i.group_end) begin
					intv_q <= '0;
					pin_q  <= '0;
					open_q <= '0;
				end else begin
					intv_q <= intv_n;
					pin_q  <= pin_n;
					open_q <= open_n;
				end
				psum_q <= flags_i.stream_end ? '0 : psum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_i.valid) begin
			slot_q     <= flags_i.placed ? slot_x[ffisa_pkg::SLOT_OUT_W-1:0] : '0;
			assigned_q <= flags_i.placed;
			reused_q   <= flags_i.reused;
			alias_q    <= flags_i.alias_valid;
			asym_q     <= flags_i.alias_valid ? asym_x[ffisa_pkg::ALIAS_W-1:0] : '0;
			ovf_q      <= !flags_i.pinned && !flags_i.placed;
			gvirt_q    <= flags_i.group_end ? intv_n : '0;
			gphys_q    <= flags_i.group_end ? phys_n : '0;
			gpin_q     <= flags_i.group_end ? pin_n : '0;
			tphys_q    <= psum_n;
			last_q     <= flags_i.stream_end;
		end
	end

	assign valid_o        = valid_q;
	assign slot_index     = slot_q;
	assign assigned       = assigned_q;
	assign reused         = reused_q;
	assign alias_valid    = alias_q;
	assign alias_symbol   = asym_q;
	assign overflow       = ovf_q;
	assign group_virtual  = gvirt_q;
	assign group_physical = gphys_q;
	assign group_pinned   = gpin_q;
	assign physical_total = tphys_q;
	assign last           = last_q;

endmodule
`default_nettype wire

// ===== sv/first_fit_interval_slot_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_interval_slot_allocator
// First-fit slot allocation of sorted live intervals on a chain of slot cells.
//
// Input channel (in_valid / in_stall): one live interval per beat, sorted by
// group, start and end. Output channel (out_valid / out_stall): one result
// beat per interval, in order. Config channel (cfg_valid / cfg_ready, ready
// always high): bit 0 of cfg_data sets alias_enable; write it only while idle.
// Each interval passes through the cell chain, one register per slot, and
// then the output register; a new interval is taken every cycle while
// nothing stalls.
// When out_stall holds a waiting result, the whole chain freezes and
// in_stall goes high until the result is taken.
// Reset closes all slots, clears all counters, empties the chain and sets
// alias_enable to 1. Slot contents are only read once opened, so they need
// no clearing.
// ----------------------------------------------------------------------------
module first_fit_interval_slot_allocator #(
	parameter int MAX_SLOTS = ffisa_pkg::DEF_MAX_SLOTS,
	parameter int POS_BITS  = ffisa_pkg::DEF_POS_BITS,
	parameter int SYM_BITS  = ffisa_pkg::DEF_SYM_BITS
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire     [SYM_BITS-1:0]                symbol_id,
	input  wire     [POS_BITS-1:0]                start_pos,
	input  wire     [POS_BITS-1:0]                end_pos,
	input  wire                                   pinned,
	input  wire                                   group_last,
	input  wire                                   stream_last,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic    [ffisa_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic                                  assigned,
	output logic                                  reused,
	output logic                                  alias_valid,
	output logic    [ffisa_pkg::ALIAS_W-1:0]      alias_symbol,
	output logic                                  overflow,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_virtual,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_physical,
	output logic    [ffisa_pkg::CNT_W-1:0]        group_pinned,
	output logic    [ffisa_pkg::CNT_W-1:0]        physical_total,
	output logic                                  last,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire                                   cfg_data
);

	localparam int SLOT_W = $clog2(MAX_SLOTS);

	logic advance;
	logic alias_en_q;

	ffisa_pkg::flags_t   flags_c [MAX_SLOTS+1];
	logic [SYM_BITS-1:0] sym_c   [MAX_SLOTS+1];
	logic [POS_BITS-1:0] start_c [MAX_SLOTS+1];
	logic [POS_BITS-1:0] end_c   [MAX_SLOTS+1];
	logic [SLOT_W-1:0]   slot_c  [MAX_SLOTS+1];
	logic [SYM_BITS-1:0] asym_c  [MAX_SLOTS+1];

	assign advance   = !out_valid || !out_stall;
	assign in_stall  = !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alias_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			alias_en_q <= cfg_data;
		end
	end

	always_comb begin
		flags_c[0]             = '0;
		flags_c[0].valid       = in_valid;
		flags_c[0].pinned      = pinned;
		flags_c[0].stream_end  = stream_last;
		flags_c[0].group_end   = group_last | stream_last;
		sym_c[0]               = symbol_id;
		start_c[0]             = start_pos;
		end_c[0]               = end_pos;
		slot_c[0]              = '0;
		asym_c[0]              = '0;
	end

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		ffisa_cell #(
			.POS_BITS (POS_BITS),
			.SYM_BITS (SYM_BITS),
			.SLOT_W   (SLOT_W),
			.IDX      (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (advance),
			.alias_enable (alias_en_q),
			.flags_i      (flags_c[i]),
			.sym_i        (sym_c[i]),
			.start_i      (start_c[i]),
			.end_i        (end_c[i]),
			.slot_i       (slot_c[i]),
			.asym_i       (asym_c[i]),
			.flags_o      (flags_c[i+1]),
			.sym_o        (sym_c[i+1]),
			.start_o      (start_c[i+1]),
			.end_o        (end_c[i+1]),
			.slot_o       (slot_c[i+1]),
			.asym_o       (asym_c[i+1])
		);
	end

	ffisa_tally #(
		.MAX_SLOTS (MAX_SLOTS),
		.SYM_BITS  (SYM_BITS),
		.SLOT_W    (SLOT_W)
	) u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.flags_i        (flags_c[MAX_SLOTS]),
		.slot_i         (slot_c[MAX_SLOTS]),
		.asym_i         (asym_c[MAX_SLOTS]),
		.valid_o        (out_valid),
		.slot_index     (slot_index),
		.assigned       (assigned),
		.reused         (reused),
		.alias_valid    (alias_valid),
		.alias_symbol   (alias_symbol),
		.overflow       (overflow),
		.group_virtual  (group_virtual),
		.group_physical (group_physical),
		.group_pinned   (group_pinned),
		.physical_total (physical_total),
		.last           (last)
	);

endmodule
`default_nettype wire

// ===== verif/first_fit_interval_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_interval_slot_allocator_tb
// Self-checking bench for the first-fit interval slot allocator. A short
// table of intervals, ten of them with hand-worked results, opens the run.
// Random groups follow: sorted groups, crowded groups that can run out of
// slots, and raw noise. A final interval closes the stream. Each group
// phase writes its own alias setting. A behavioral allocator predicts the
// other result beats, and each beat is compared field by field.
// ----------------------------------------------------------------------------
module first_fit_interval_slot_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SLOTS      = ffisa_pkg::DEF_MAX_SLOTS;
	localparam int CNT_SAT        = 65535;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 135;
	localparam int MAX_REPORTS    = 100;

	typedef enum int {GRP_NORMAL, GRP_CROWDED, GRP_NOISE} group_kind_t;

	typedef struct packed {
		logic [15:0] sym;
		logic [15:0] start_p;
		logic [15:0] end_p;
		logic        pinned;
		logic        glast;
		logic        slast;
	} interval_t;

	typedef struct packed {
		logic [5:0]  slot;
		logic        asg;
		logic        reu;
		logic        alv;
		logic [15:0] als;
		logic        ovf;
		logic [15:0] gv;
		logic [15:0] gp;
		logic [15:0] gpin;
		logic [15:0] tp;
		logic        lst;
	} result_t;

	typedef struct packed {
		logic    fixed;
		result_t r;
	} worked_t;

	typedef struct packed {
		interval_t stim;
		logic      fixed;
		result_t   want;
	} dir_row_t;

	localparam int DIR_ROWS = 18;

	// hand-worked rows assume alias reporting on (reset value)
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{16'h0001, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd0, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{16'h0002, 16'd1,     16'd5,     1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd0, 1'b1, 1'b1, 1'b1, 16'h1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{16'h0003, 16'd5,     16'hFFFF,  1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd1, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{16'h0001, 16'd6,     16'd6,     1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd0, 1'b1, 1'b1, 1'b0, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
		'{'{16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 1'b0}, 1'b1,
			'{6'd0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 16'd5, 16'd3, 16'd1, 16'd3, 1'b0}},
		'{'{16'h0000, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd0, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd3, 1'b0}},
		'{'{16'hFFFF, 16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd0, 1'b1, 1'b1, 1'b1, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd3, 1'b0}},
		'{'{16'h5555, 16'hFFFF,  16'hFFFF,  1'b0, 1'b0, 1'b0}, 1'b1,
			'{6'd1, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd3, 1'b0}},
		'{'{16'hAAAA, 16'h8000,  16'h7FFF,  1'b0, 1'b0, 1'b1}, 1'b1,
			'{6'd2, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 16'd4, 16'd3, 16'd0, 16'd6, 1'b1}},
		'{'{16'h0F0F, 16'h1234,  16'h1234,  1'b1, 1'b1, 1'b1}, 1'b1,
			'{6'd0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1}},
		'{'{16'h1111, 16'd100,   16'd50,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{16'h2222, 16'd40,    16'd60,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{16'h1111, 16'd51,    16'd70,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{16'h3333, 16'd61,    16'd61,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{16'h3333, 16'd71,    16'd80,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{16'h4444, 16'd0,     16'hFFFF,  1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{16'hAAAA, 16'h5555,  16'hAAAA,  1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{16'h5555, 16'hAAAA,  16'h5555,  1'b1, 1'b0, 1'b1}, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] symbol_id = '0;
	logic [15:0] start_pos = '0;
	logic [15:0] end_pos = '0;
	logic        pinned = 1'b0;
	logic        group_last = 1'b0;
	logic        stream_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  slot_index;
	logic        assigned;
	logic        reused;
	logic        alias_valid;
	logic [15:0] alias_symbol;
	logic        overflow;
	logic [15:0] group_virtual;
	logic [15:0] group_physical;
	logic [15:0] group_pinned;
	logic [15:0] physical_total;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	first_fit_interval_slot_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.symbol_id     (symbol_id),
		.start_pos     (start_pos),
		.end_pos       (end_pos),
		.pinned        (pinned),
		.group_last    (group_last),
		.stream_last   (stream_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.slot_index    (slot_index),
		.assigned      (assigned),
		.reused        (reused),
		.alias_valid   (alias_valid),
		.alias_symbol  (alias_symbol),
		.overflow      (overflow),
		.group_virtual (group_virtual),
		.group_physical(group_physical),
		.group_pinned  (group_pinned),
		.physical_total(physical_total),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// allocator shadow state
	logic [15:0] slot_end   [MAX_SLOTS];
	logic [15:0] slot_owner [MAX_SLOTS];
	int          slots_open = 0;
	int          pinned_count = 0;
	int          interval_count = 0;
	int          physical_sum = 0;
	logic        alias_en = 1'b1;

	result_t     expected_results [$];
	worked_t     worked_results [$];
	int          mismatches = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          groups_closed = 0;
	int          reuse_hits = 0;
	int          alias_hits = 0;
	int          overflow_hits = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          stall_mode = 0;
	int          stall_hold = 0;

	function automatic int sat16(input int x);
		return (x > CNT_SAT) ? CNT_SAT : x;
	endfunction

	function automatic result_t allocate_interval(input interval_t iv);
		result_t r;
		int      hit;
		int      phys;
		r = '0;
		hit = -1;
		interval_count = sat16(interval_count + 1);
		if (iv.pinned) begin
			pinned_count = sat16(pinned_count + 1);
		end else begin
			for (int i = 0; i < slots_open; i++)
				if (hit < 0 && slot_end[i] < iv.start_p)
					hit = i;
			if (hit >= 0) begin
				r.slot = 6'(hit);
				r.asg = 1'b1;
				r.reu = 1'b1;
				reuse_hits++;
				if (alias_en && slot_owner[hit] != iv.sym) begin
					r.alv = 1'b1;
					r.als = slot_owner[hit];
					alias_hits++;
				end
				slot_end[hit] = iv.end_p;
			end else if (slots_open < MAX_SLOTS) begin
				r.slot = 6'(slots_open);
				r.asg = 1'b1;
				slot_owner[slots_open] = iv.sym;
				slot_end[slots_open] = iv.end_p;
				slots_open++;
			end else begin
				r.ovf = 1'b1;
				overflow_hits++;
			end
		end
		if (iv.glast || iv.slast) begin
			phys = sat16(slots_open + pinned_count);
			r.gv = 16'(interval_count);
			r.gpin = 16'(pinned_count);
			r.gp = 16'(phys);
			physical_sum = sat16(physical_sum + phys);
			slots_open = 0;
			pinned_count = 0;
			interval_count = 0;
			groups_closed++;
		end
		r.tp = 16'(physical_sum);
		r.lst = iv.slast;
		if (iv.slast)
			physical_sum = 0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			// keep the log readable on a badly broken block
			if (mismatches <= MAX_REPORTS)
				$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// predictor and scoreboard, sampled at the rising edge
	always @(posedge clk) begin
		result_t   want;
		worked_t   worked;
		interval_t iv;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				alias_en = cfg_data;
			if (out_valid && !out_stall) begin
				beats_out++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$error("result beat with no expectation pending");
				end else begin
					want = expected_results.pop_front();
					check_field("slot_index", 16'(want.slot), 16'(slot_index));
					check_field("assigned", 16'(want.asg), 16'(assigned));
					check_field("reused", 16'(want.reu), 16'(reused));
					check_field("alias_valid", 16'(want.alv), 16'(alias_valid));
					check_field("alias_symbol", want.als, alias_symbol);
					check_field("overflow", 16'(want.ovf), 16'(overflow));
					check_field("group_virtual", want.gv, group_virtual);
					check_field("group_physical", want.gp, group_physical);
					check_field("group_pinned", want.gpin, group_pinned);
					check_field("physical_total", want.tp, physical_total);
					check_field("last", 16'(want.lst), 16'(last));
				end
			end
			if (in_valid && !in_stall) begin
				beats_in++;
				iv = '{symbol_id, start_pos, end_pos, pinned, group_last, stream_last};
				want = allocate_interval(iv);
				worked = (worked_results.size() != 0) ? worked_results.pop_front() : '0;
				expected_results.insert(expected_results.size(), worked.fixed ? worked.r : want);
			end
		end
	end

	// receiver stall pattern: free, light, heavy, or long runs
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_hold <= $urandom_range(30, 300);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 7) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
			$display("first_fit_interval_slot_allocator_tb failed");
			$finish;
		end
	end

	// called at a rising edge, returns at the edge where the beat is taken
	task automatic put_interval(input interval_t iv, input logic fixed, input result_t r);
		worked_t w;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		w.fixed = fixed;
		w.r = r;
		worked_results.insert(worked_results.size(), w);
		in_valid <= 1'b1;
		symbol_id <= iv.sym;
		start_pos <= iv.start_p;
		end_pos <= iv.end_p;
		pinned <= iv.pinned;
		group_last <= iv.glast;
		stream_last <= iv.slast;
		do @(posedge clk); while (in_stall !== 1'b0);
		burst_left--;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_alias_enable(input logic value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_group(input group_kind_t kind, output int sent);
		interval_t iv;
		int        n;
		int        pos;
		int        len;
		int        prev_len;
		int        step;
		int        sym_base;
		int        mark;
		n = (kind == GRP_CROWDED) ? $urandom_range(60, 72)
			: (kind == GRP_NOISE) ? $urandom_range(1, 8) : $urandom_range(1, 24);
		pos = ($urandom_range(0, 3) == 0) ? $urandom_range(65480, 65535)
			: $urandom_range(0, 65535);
		sym_base = $urandom_range(0, 65535);
		prev_len = 0;
		for (int k = 0; k < n; k++) begin
			if (kind == GRP_NOISE) begin
				iv = '{16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
					($urandom_range(0, 3) == 0), ($urandom_range(0, 7) == 0)};
			end else begin
				if (kind == GRP_CROWDED) begin
					step = 0;
					len = prev_len + $urandom_range(0, 3);
				end else begin
					step = $urandom_range(0, 6);
					len = (step == 0) ? prev_len + $urandom_range(0, 20)
						: $urandom_range(0, 24);
				end
				pos = sat16(pos + step);
				prev_len = len;
				iv.sym = 16'(sym_base + $urandom_range(0, 7));
				iv.start_p = 16'(pos);
				iv.end_p = 16'(sat16(pos + len));
				iv.pinned = ($urandom_range(0, (kind == GRP_CROWDED) ? 15 : 9) == 0);
				iv.glast = 1'b0;
				iv.slast = 1'b0;
				if (k == n - 1) begin
					mark = $urandom_range(0, 9);
					iv.glast = (mark != 7);
					iv.slast = (mark >= 7);
				end
			end
			put_interval(iv, 1'b0, '0);
		end
		sent = n;
	endtask

	initial begin
		interval_t   iv;
		group_kind_t kind;
		int          pick;
		int          sent;
		int          phase_items;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_ROWS; k++)
			put_interval(directed_rows[k].stim, directed_rows[k].fixed,
				directed_rows[k].want);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_alias_enable(ph % 2 == 1);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				kind = (pick < 12 || phase_items == 0) ? GRP_CROWDED
					: (pick < 30) ? GRP_NOISE : GRP_NORMAL;
				send_group(kind, sent);
				phase_items += sent;
			end
			drain();
		end

		// close the stream with alias reporting back on
		write_alias_enable(1'b1);
		send_group(GRP_NORMAL, sent);
		iv = '{16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1, 1'b1};
		put_interval(iv, 1'b0, '0);
		drain();
		repeat (2 * MAX_SLOTS) @(posedge clk);

		$display("run covered %0d intervals, %0d results, %0d groups",
			beats_in, beats_out, groups_closed);
		$display("slot reuses %0d, aliases %0d, overflows %0d, mismatches %0d",
			reuse_hits, alias_hits, overflow_hits, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("first_fit_interval_slot_allocator_tb passed");
		else
			$display("first_fit_interval_slot_allocator_tb failed");
		$finish;
	end

endmodule

// ===== first_fit_interval_slot_allocator.f =====
sv/ffisa_pkg.sv
sv/ffisa_cell.sv
sv/ffisa_tally.sv
sv/first_fit_interval_slot_allocator.sv
verif/first_fit_interval_slot_allocator_tb.sv
